/* rtl/sphk_pkg.sv */
package sphk_pkg;

  // Field widths fixed by the interface
  localparam int Q_W   = 18;
  localparam int OUT_W = 24;

  // Default fixed-point formats of the ports
  localparam int DEF_IN_FRAC_BITS  = 16;
  localparam int DEF_OUT_FRAC_BITS = 22;

  // Working format: signed, WF fraction bits, magnitude below 2^(WW-1)
  localparam int WF = 28;
  localparam int WW = 33;

  typedef logic signed [WW-1:0] fx_t;

  // Which polynomial piece an item falls in
  typedef enum logic [2:0] {
    PC_ZERO,
    PC_CIN,
    PC_COUT,
    PC_QIN,
    PC_QMID,
    PC_QOUT
  } piece_t;

  // Breakpoints, unsigned with WF fraction bits
  localparam logic [63:0] BRK_HALF      = 64'd1 << (WF - 1);
  localparam logic [63:0] BRK_ONE       = 64'd1 << WF;
  localparam logic [63:0] BRK_THREEHALF = 64'd3 << (WF - 1);
  localparam logic [63:0] BRK_TWO       = 64'd2 << WF;
  localparam logic [63:0] BRK_THREE     = 64'd3 << WF;

  // Coefficients: round(n/d * 2^WF), ties up
  localparam fx_t K_ONE      = fx_t'(((64'd1 << WF) + 64'd0) / 64'd1);
  localparam fx_t K_THREE    = fx_t'(((64'd3 << WF) + 64'd0) / 64'd1);
  localparam fx_t K_INVPI    = fx_t'(((64'd3183098862 << WF) + 64'd5000000000)
                                     / 64'd10000000000);
  localparam fx_t K_075      = fx_t'(((64'd3 << WF) + 64'd2) / 64'd4);
  localparam fx_t K_150      = fx_t'(((64'd3 << WF) + 64'd1) / 64'd2);
  localparam fx_t K_225      = fx_t'(((64'd9 << WF) + 64'd2) / 64'd4);
  localparam fx_t K_025      = fx_t'(((64'd1 << WF) + 64'd2) / 64'd4);
  localparam fx_t K_10_21    = fx_t'(((64'd10 << WF) + 64'd10) / 64'd21);
  localparam fx_t K_4_135    = fx_t'(((64'd4 << WF) + 64'd67) / 64'd135);
  localparam fx_t K_31_135   = fx_t'(((64'd31 << WF) + 64'd67) / 64'd135);
  localparam fx_t K_10_27    = fx_t'(((64'd10 << WF) + 64'd13) / 64'd27);
  localparam fx_t K_32_567   = fx_t'(((64'd32 << WF) + 64'd283) / 64'd567);
  localparam fx_t K_248_567  = fx_t'(((64'd248 << WF) + 64'd283) / 64'd567);
  localparam fx_t K_12_7     = fx_t'(((64'd12 << WF) + 64'd3) / 64'd7);
  localparam fx_t K_38_21    = fx_t'(((64'd38 << WF) + 64'd10) / 64'd21);
  localparam fx_t K_1_7      = fx_t'(((64'd1 << WF) + 64'd3) / 64'd7);
  localparam fx_t K_20_21    = fx_t'(((64'd20 << WF) + 64'd10) / 64'd21);
  localparam fx_t K_400_567  = fx_t'(((64'd400 << WF) + 64'd283) / 64'd567);
  localparam fx_t K_03       = fx_t'(((64'd3 << WF) + 64'd5) / 64'd10);
  localparam fx_t K_19       = fx_t'(((64'd19 << WF) + 64'd5) / 64'd10);
  localparam fx_t K_12       = fx_t'(((64'd6 << WF) + 64'd2) / 64'd5);
  localparam fx_t K_10875    = fx_t'(((64'd87 << WF) + 64'd40) / 64'd80);
  localparam fx_t K_1125     = fx_t'(((64'd9 << WF) + 64'd4) / 64'd8);

  // Fixed-point product, magnitude rounded half away from zero
  function automatic fx_t fmul(input fx_t a, input fx_t b);
    logic [WW-1:0]   ma;
    logic [WW-1:0]   mb;
    logic [2*WW-1:0] p;
    logic [2*WW-1:0] r;
    logic            neg;
    neg = a[WW-1] ^ b[WW-1];
    ma  = a[WW-1] ? -a : a;
    mb  = b[WW-1] ? -b : b;
    p   = {{WW{1'b0}}, ma} * {{WW{1'b0}}, mb};
    r   = (p + ((2*WW)'(1) << (WF - 1))) >> WF;
    return neg ? -fx_t'(r[WW-1:0]) : fx_t'(r[WW-1:0]);
  endfunction

endpackage

/* rtl/sph_spline_kernel_eval_core.sv */
// 3D SPH smoothing kernel: value W(q) and slope dW/dq for a distance q = r/h.
// Input channel: in_valid / in_stall with in_q (unsigned, IN_FRAC_BITS fraction
// bits). Result channel: out_valid / out_stall with out_kernel_value and
// out_kernel_slope (two's complement, OUT_FRAC_BITS fraction bits, saturated).
// A request moves when valid is high and stall is low at a rising edge.
// cfg_wr_en with cfg_kernel_select picks the kernel: 0 cubic, 1 quartic. Write
// it only while no request is in flight.
// Pipeline: seven register stages (entry, five multiply stages, result).
// Throughput: one request per cycle while nothing stalls. The first three
// of the five multiply stages hold one multiplier per result field, the last
// two one for the value only; the longest polynomial chain is five dependent
// products.
// Stall: out_stall holds the result register; bubbles further up still fill,
// and in_stall rises once every stage holds a request.
// Reset (rst_n low at a clock edge) empties the pipeline and selects the cubic
// kernel.
module sph_spline_kernel_eval_core
  import sphk_pkg::*;
#(
  parameter int IN_FRAC_BITS  = DEF_IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_kernel_select,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [Q_W-1:0]          in_q,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_kernel_value,
  output logic signed [OUT_W-1:0] out_kernel_slope
);

  localparam int XW  = Q_W + WF - IN_FRAC_BITS;
  localparam int SH  = WF - OUT_FRAC_BITS;
  localparam int SHR = (SH > 0) ? SH : 1;
  localparam int SHL = (SH < 0) ? -SH : 0;
  localparam int OW  = WW + 3;
  localparam logic signed [OW-1:0] SAT_HI = OW'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

  // Round to output format and saturate
  function automatic logic signed [OUT_W-1:0] to_out(input fx_t v);
    logic signed [OW-1:0] vx;
    logic signed [OW-1:0] r;
    logic [OW-1:0]        mag;
    logic [OW-1:0]        rm;
    vx  = OW'(v);
    mag = vx[OW-1] ? -vx : vx;
    rm  = (mag + (OW'(1) << (SHR - 1))) >> SHR;
    if (SH > 0) begin
      r = vx[OW-1] ? -$signed(rm) : $signed(rm);
    end else if (SH == 0) begin
      r = vx;
    end else begin
      r = vx <<< SHL;
    end
    if (r > SAT_HI) begin
      return SAT_HI[OUT_W-1:0];
    end else if (r < SAT_LO) begin
      return SAT_LO[OUT_W-1:0];
    end else begin
      return r[OUT_W-1:0];
    end
  endfunction

  logic                    sel_r;
  logic [5:0]              vld_r;
  logic [6:0]              rdy;
  fx_t                     x_r  [0:5];
  fx_t                     t_r  [0:5];
  piece_t                  pc_r [0:5];
  fx_t                     a_r  [1:5];
  fx_t                     b_r  [1:5];
  fx_t                     x0_nxt;
  fx_t                     t0_nxt;
  piece_t                  pc0_nxt;
  fx_t                     t_nxt [1:5];
  fx_t                     a_nxt [1:5];
  fx_t                     b_nxt [1:5];
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_value_r;
  logic signed [OUT_W-1:0] out_slope_r;
  logic signed [OUT_W-1:0] out_value_nxt;
  logic signed [OUT_W-1:0] out_slope_nxt;

  // Stage ready chain: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[6] = !out_valid_r || !out_stall;
    for (int k = 5; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // Entry: piece selection and piece variable
  always_comb begin
    logic [XW-1:0] xq;
    logic [63:0]   x64;
    xq      = XW'(in_q) << (WF - IN_FRAC_BITS);
    x64     = 64'(xq);
    x0_nxt  = fx_t'({1'b0, x64[WW-2:0]});
    t0_nxt  = x0_nxt;
    pc0_nxt = PC_ZERO;
    if (!sel_r) begin
      if (x64 < BRK_ONE) begin
        pc0_nxt = PC_CIN;
      end else if (x64 < BRK_TWO) begin
        pc0_nxt = PC_COUT;
        t0_nxt  = fx_t'(BRK_TWO[WW-1:0]) - x0_nxt;
      end
    end else begin
      if (x64 > BRK_THREE) begin
        pc0_nxt = PC_ZERO;
      end else if (x64 > BRK_THREEHALF) begin
        pc0_nxt = PC_QOUT;
        t0_nxt  = K_THREE - x0_nxt;
      end else if (x64 > BRK_HALF) begin
        pc0_nxt = PC_QMID;
      end else begin
        pc0_nxt = PC_QIN;
      end
    end
  end

  // Multiply stage 1: first product of each lane
  always_comb begin
    fx_t  oa1, oa2, ob1, ob2, pa, pb, ca, cb;
    logic na, nb;
    oa1 = '0; oa2 = '0; ob1 = '0; ob2 = '0;
    ca  = '0; cb  = '0; na  = 1'b0; nb  = 1'b0;
    case (pc_r[0]) inside
      PC_CIN: begin
        oa1 = K_075;   oa2 = x_r[0]; ca = -K_150;
        ob1 = K_225;   ob2 = x_r[0]; cb = -K_THREE;
      end
      PC_COUT, PC_QOUT, PC_QIN: begin
        oa1 = t_r[0];  oa2 = t_r[0];
        ob1 = t_r[0];  ob2 = t_r[0];
      end
      PC_QMID: begin
        oa1 = K_31_135;  oa2 = x_r[0]; na = 1'b1; ca = K_12;
        ob1 = K_248_567; ob2 = x_r[0]; nb = 1'b1; cb = K_12_7;
      end
      default: ;
    endcase
    pa       = fmul(oa1, oa2);
    pb       = fmul(ob1, ob2);
    a_nxt[1] = (na ? -pa : pa) + ca;
    b_nxt[1] = (nb ? -pb : pb) + cb;
    // inner quartic piece keeps x^2 as its piece variable from here on
    t_nxt[1] = (pc_r[0] == PC_QIN) ? pa : t_r[0];
  end

  // Multiply stage 2
  always_comb begin
    fx_t oa1, oa2, ob1, ob2, pa, pb, ca, cb;
    oa1 = '0; oa2 = '0; ob1 = '0; ob2 = '0; ca = '0; cb = '0;
    case (pc_r[1])
      PC_CIN: begin
        oa1 = a_r[1]; oa2 = x_r[1];
        ob1 = b_r[1]; ob2 = x_r[1];
      end
      PC_COUT: begin
        oa1 = a_r[1]; oa2 = t_r[1];
        ob1 = K_075;  ob2 = b_r[1];
      end
      PC_QOUT: begin
        oa1 = a_r[1]; oa2 = t_r[1];
        ob1 = b_r[1]; ob2 = t_r[1];
      end
      PC_QMID: begin
        oa1 = a_r[1]; oa2 = x_r[1]; ca = -K_19;
        ob1 = b_r[1]; ob2 = x_r[1]; cb = -K_38_21;
      end
      PC_QIN: begin
        oa1 = K_10_27;   oa2 = a_r[1]; ca = -K_ONE;
        ob1 = K_400_567; ob2 = b_r[1]; cb = -K_20_21;
      end
      default: ;
    endcase
    pa       = fmul(oa1, oa2);
    pb       = fmul(ob1, ob2);
    a_nxt[2] = pa + ca;
    b_nxt[2] = pb + cb;
    t_nxt[2] = t_r[1];
  end

  // Multiply stage 3: slope lane finishes here
  always_comb begin
    fx_t  oa1, oa2, ob1, ob2, pa, pb, ca, cb;
    logic nb;
    oa1 = '0; oa2 = '0; ob1 = '0; ob2 = '0; ca = '0; cb = '0; nb = 1'b0;
    case (pc_r[2])
      PC_CIN: begin
        oa1 = a_r[2];  oa2 = x_r[2]; ca = K_ONE;
        ob1 = K_INVPI; ob2 = b_r[2];
      end
      PC_COUT: begin
        oa1 = K_025;   oa2 = a_r[2];
        ob1 = K_INVPI; ob2 = b_r[2]; nb = 1'b1;
      end
      PC_QOUT: begin
        oa1 = a_r[2];   oa2 = t_r[2];
        ob1 = K_32_567; ob2 = b_r[2]; nb = 1'b1;
      end
      PC_QMID: begin
        oa1 = a_r[2]; oa2 = x_r[2]; ca = K_03;
        ob1 = x_r[2]; ob2 = b_r[2]; cb = K_1_7;
      end
      PC_QIN: begin
        oa1 = a_r[2]; oa2 = t_r[2]; ca = K_1125;
        ob1 = x_r[2]; ob2 = b_r[2];
      end
      default: ;
    endcase
    pa       = fmul(oa1, oa2);
    pb       = fmul(ob1, ob2);
    a_nxt[3] = pa + ca;
    b_nxt[3] = (nb ? -pb : pb) + cb;
    t_nxt[3] = t_r[2];
  end

  // Multiply stage 4: value lane only
  always_comb begin
    fx_t oa1, oa2, pa, ca;
    oa1 = '0; oa2 = '0; ca = '0;
    case (pc_r[3]) inside
      PC_CIN, PC_COUT: begin
        oa1 = K_INVPI; oa2 = a_r[3];
      end
      PC_QOUT: begin
        oa1 = K_4_135; oa2 = a_r[3];
      end
      PC_QMID: begin
        oa1 = a_r[3]; oa2 = x_r[3]; ca = K_10875;
      end
      PC_QIN: begin
        oa1 = K_10_21; oa2 = a_r[3];
      end
      default: ;
    endcase
    pa       = fmul(oa1, oa2);
    a_nxt[4] = pa + ca;
    b_nxt[4] = b_r[3];
    t_nxt[4] = t_r[3];
  end

  // Multiply stage 5: final scale of the quartic outer and middle pieces
  always_comb begin
    fx_t oa1;
    case (pc_r[4]) inside
      PC_QOUT, PC_QMID: oa1 = K_10_21;
      // unit factor passes the value through exactly
      default:          oa1 = K_ONE;
    endcase
    a_nxt[5] = fmul(oa1, a_r[4]);
    b_nxt[5] = b_r[4];
    t_nxt[5] = t_r[4];
  end

  // Output conversion; outside support both fields are zero
  always_comb begin
    if (pc_r[5] == PC_ZERO) begin
      out_value_nxt = '0;
      out_slope_nxt = '0;
    end else begin
      out_value_nxt = to_out(a_r[5]);
      out_slope_nxt = to_out(b_r[5]);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sel_r <= cfg_kernel_select;
      end
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[6]) begin
        out_valid_r <= vld_r[5];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r[0]  <= x0_nxt;
      t_r[0]  <= t0_nxt;
      pc_r[0] <= pc0_nxt;
    end
    for (int k = 1; k < 6; k++) begin
      if (rdy[k]) begin
        x_r[k]  <= x_r[k-1];
        t_r[k]  <= t_nxt[k];
        pc_r[k] <= pc_r[k-1];
        a_r[k]  <= a_nxt[k];
        b_r[k]  <= b_nxt[k];
      end
    end
    if (rdy[6]) begin
      out_value_r <= out_value_nxt;
      out_slope_r <= out_slope_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kernel_value = out_value_r;
  assign out_kernel_slope = out_slope_r;

endmodule

/* dv/sph_kernel_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the kernel evaluator, predicts W(q) and dW/dq for
// every accepted request and compares them with the results in order.
module sph_kernel_checker
  import sphk_pkg::*;
#(
  parameter int IN_FRAC_BITS  = DEF_IN_FRAC_BITS,
  parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_kernel_select,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [Q_W-1:0]          in_q,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [OUT_W-1:0] out_kernel_value,
  input  logic signed [OUT_W-1:0] out_kernel_slope,
  output int                      mismatch_count,
  output int                      results_due
);

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic signed [OUT_W-1:0] slope;
  } kernel_pair_t;

  // round(num/den * 2^WF), ties up
  function automatic longint fx_ratio(input longint unsigned num,
                                      input longint unsigned den);
    return longint'(((num << WF) + den / 2) / den);
  endfunction

  localparam longint C_ONE       = fx_ratio(1, 1);
  localparam longint C_HALF      = fx_ratio(1, 2);
  localparam longint C_TWO       = fx_ratio(2, 1);
  localparam longint C_THREEHALF = fx_ratio(3, 2);
  localparam longint C_THREE     = fx_ratio(3, 1);
  localparam longint C_INVPI     = fx_ratio(64'd3183098862, 64'd10000000000);
  localparam longint C_075       = fx_ratio(3, 4);
  localparam longint C_150       = fx_ratio(3, 2);
  localparam longint C_225       = fx_ratio(9, 4);
  localparam longint C_025       = fx_ratio(1, 4);
  localparam longint C_10_21     = fx_ratio(10, 21);
  localparam longint C_4_135     = fx_ratio(4, 135);
  localparam longint C_31_135    = fx_ratio(31, 135);
  localparam longint C_10_27     = fx_ratio(10, 27);
  localparam longint C_32_567    = fx_ratio(32, 567);
  localparam longint C_248_567   = fx_ratio(248, 567);
  localparam longint C_12_7      = fx_ratio(12, 7);
  localparam longint C_38_21     = fx_ratio(38, 21);
  localparam longint C_1_7       = fx_ratio(1, 7);
  localparam longint C_20_21     = fx_ratio(20, 21);
  localparam longint C_400_567   = fx_ratio(400, 567);
  localparam longint C_03        = fx_ratio(3, 10);
  localparam longint C_19        = fx_ratio(19, 10);
  localparam longint C_12        = fx_ratio(6, 5);
  localparam longint C_10875     = fx_ratio(87, 80);
  localparam longint C_1125      = fx_ratio(9, 8);

  localparam longint SAT_HI = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (OUT_W - 1));

  logic         quartic_sel;
  kernel_pair_t kernel_pairs_due[$];
  int           fail_tally = 0;

  // Product of two working-format values, rounded half away from zero
  function automatic longint fx_mul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    logic [127:0]    prod;
    ma   = (a < 0) ? -a : a;
    mb   = (b < 0) ? -b : b;
    prod = {64'd0, ma} * {64'd0, mb};
    prod = (prod + (128'd1 << (WF - 1))) >> WF;
    return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Working format to port format: round, or shift up, then saturate
  function automatic logic signed [OUT_W-1:0] to_port(input longint v);
    longint unsigned mag;
    longint          r;
    int              sh;
    sh = WF - OUT_FRAC_BITS;
    if (sh > 0) begin
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      r   = (v < 0) ? -longint'(mag) : longint'(mag);
    end else begin
      r = v <<< (-sh);
    end
    if (r > SAT_HI) r = SAT_HI;
    else if (r < SAT_LO) r = SAT_LO;
    return r[OUT_W-1:0];
  endfunction

  // Kernel value and slope for one distance
  function automatic kernel_pair_t eval_kernel(input logic quartic,
                                               input logic [Q_W-1:0] q);
    kernel_pair_t res;
    longint       x;
    longint       w;
    longint       dw;
    longint       u;
    longint       u2;
    longint       u3;
    longint       u4;
    longint       p;
    longint       d;
    x  = longint'({46'd0, q}) <<< (WF - IN_FRAC_BITS);
    w  = 0;
    dw = 0;
    if (!quartic) begin
      if (x < C_ONE) begin
        p  = fx_mul(fx_mul(fx_mul(C_075, x) - C_150, x), x) + C_ONE;
        w  = fx_mul(C_INVPI, p);
        dw = fx_mul(C_INVPI, fx_mul(fx_mul(C_225, x) - C_THREE, x));
      end else if (x < C_TWO) begin
        u  = C_TWO - x;
        u2 = fx_mul(u, u);
        u3 = fx_mul(u2, u);
        w  = fx_mul(C_INVPI, fx_mul(C_025, u3));
        dw = -fx_mul(C_INVPI, fx_mul(C_075, u2));
      end
    end else begin
      if (x > C_THREE) begin
        w  = 0;
        dw = 0;
      end else if (x > C_THREEHALF) begin
        u  = C_THREE - x;
        u2 = fx_mul(u, u);
        u3 = fx_mul(u2, u);
        u4 = fx_mul(u3, u);
        w  = fx_mul(C_10_21, fx_mul(C_4_135, u4));
        dw = -fx_mul(C_32_567, u3);
      end else if (x > C_HALF) begin
        p  = fx_mul(C_12 - fx_mul(C_31_135, x), x) - C_19;
        p  = fx_mul(p, x) + C_03;
        p  = fx_mul(p, x) + C_10875;
        d  = fx_mul(C_12_7 - fx_mul(C_248_567, x), x) - C_38_21;
        w  = fx_mul(C_10_21, p);
        dw = fx_mul(x, d) + C_1_7;
      end else begin
        u2 = fx_mul(x, x);
        p  = C_1125 + fx_mul(fx_mul(C_10_27, u2) - C_ONE, u2);
        w  = fx_mul(C_10_21, p);
        dw = fx_mul(x, fx_mul(C_400_567, u2) - C_20_21);
      end
    end
    res.value = to_port(w);
    res.slope = to_port(dw);
    return res;
  endfunction

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    kernel_pair_t want;
    if (!rst_n) begin
      quartic_sel = 1'b0;
      kernel_pairs_due.delete();
    end else begin
      if (in_valid && !in_stall)
        kernel_pairs_due.push_back(eval_kernel(quartic_sel, in_q));
      if (out_valid && !out_stall) begin
        if (kernel_pairs_due.size() == 0) begin
          $error("unexpected result: kernel_value %0d kernel_slope %0d",
                 out_kernel_value, out_kernel_slope);
          fail_tally++;
        end else begin
          want = kernel_pairs_due.pop_front();
          if (out_kernel_value !== want.value) begin
            $error("kernel_value: expected %0d, actual %0d", want.value,
                   out_kernel_value);
            fail_tally++;
          end
          if (out_kernel_slope !== want.slope) begin
            $error("kernel_slope: expected %0d, actual %0d", want.slope,
                   out_kernel_slope);
            fail_tally++;
          end
        end
      end
      // register write lands after this edge's request
      if (cfg_wr_en)
        quartic_sel = cfg_kernel_select;
    end
    mismatch_count <= fail_tally;
    results_due    <= kernel_pairs_due.size();
  end

endmodule

/* dv/tb_sph_spline_kernel_eval_core.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the kernel evaluator; checking is in the checker.
module tb_sph_spline_kernel_eval_core;
  import sphk_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int Q_MAX        = (1 << Q_W) - 1;

  // Breakpoints in input format
  localparam int Q_ONE       = 1 << DEF_IN_FRAC_BITS;
  localparam int Q_HALF      = Q_ONE / 2;
  localparam int Q_THREEHALF = 3 * Q_HALF;
  localparam int Q_TWO       = 2 * Q_ONE;
  localparam int Q_THREE     = 3 * Q_ONE;

  localparam logic KSEL_CUBIC   = 1'b0;
  localparam logic KSEL_QUARTIC = 1'b1;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic                    cfg_kernel_select;
  logic                    in_valid;
  logic                    in_stall;
  logic [Q_W-1:0]          in_q;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_kernel_value;
  logic signed [OUT_W-1:0] out_kernel_slope;
  int                      mismatch_count;
  int                      results_due;
  int                      cycle_count = 0;
  bit                      hold_req    = 1'b0;
  bit                      hold_done   = 1'b0;

  sph_spline_kernel_eval_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_kernel_select (cfg_kernel_select),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_q              (in_q),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kernel_value  (out_kernel_value),
    .out_kernel_slope  (out_kernel_slope)
  );

  sph_kernel_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_kernel_select (cfg_kernel_select),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_q              (in_q),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kernel_value  (out_kernel_value),
    .out_kernel_slope  (out_kernel_slope),
    .mismatch_count    (mismatch_count),
    .results_due       (results_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one request and hold it until taken
  task automatic push_q(input logic [Q_W-1:0] q);
    in_valid <= 1'b1;
    in_q     <= q;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      in_q     <= Q_W'($urandom_range(0, Q_MAX));
      repeat (n) @(posedge clk);
    end
  endtask

  // Drain everything in flight, then write the kernel select
  task automatic set_kernel(input logic ksel);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en         <= 1'b1;
    cfg_kernel_select <= ksel;
    @(posedge clk);
    cfg_wr_en         <= 1'b0;
  endtask

  // Mostly inside support, some round the breaks, some anywhere
  function automatic logic [Q_W-1:0] pick_q(input logic ksel);
    int roll;
    int bp;
    roll = $urandom_range(0, 99);
    if (roll < 15)
      return Q_W'($urandom_range(0, Q_MAX));
    if (roll < 30) begin
      if (ksel == KSEL_CUBIC)
        bp = ($urandom_range(0, 1) == 0) ? Q_ONE : Q_TWO;
      else
        case ($urandom_range(0, 2))
          0:       bp = Q_HALF;
          1:       bp = Q_THREEHALF;
          default: bp = Q_THREE;
        endcase
      return Q_W'(bp + $urandom_range(0, 16) - 8);
    end
    return Q_W'($urandom_range(0, (ksel == KSEL_CUBIC) ? Q_TWO + 4000 : Q_THREE + 4000));
  endfunction

  // Random bursts with random gaps between them
  task automatic stream_random(input logic ksel, input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        push_q(pick_q(ksel));
        sent++;
        if (sent == 100) hold_req = 1'b1;
      end
      idle_for(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
    end
  endtask

  // Edges of each piece, extremes and alternating bit patterns
  task automatic directed_cubic();
    int pts[12] = '{0, 1, Q_HALF, Q_ONE - 1, Q_ONE, Q_ONE + 1, Q_TWO - 1, Q_TWO,
                    Q_TWO + 1, Q_MAX, 'h2AAAA, 'h15555};
    foreach (pts[i]) push_q(Q_W'(pts[i]));
  endtask

  task automatic directed_quartic();
    int pts[12] = '{0, 1, Q_HALF - 1, Q_HALF, Q_HALF + 1, Q_THREEHALF - 1,
                    Q_THREEHALF, Q_THREEHALF + 1, Q_THREE - 1, Q_THREE,
                    Q_THREE + 1, Q_MAX};
    foreach (pts[i]) push_q(Q_W'(pts[i]));
  endtask

  // Result side back-pressure: segments of differing stall density
  initial begin : result_backpressure
    int seg;
    int mode;
    out_stall <= 1'b0;
    forever begin
      seg  = $urandom_range(20, 200);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < seg; k++) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          // long hold-off so the pipeline fills and stalls its input
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
          out_stall <= 1'b0;
          break;
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= k[0];
        endcase
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_kernel_select <= KSEL_CUBIC;
    in_valid          <= 1'b0;
    in_q              <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_kernel(KSEL_CUBIC);
    directed_cubic();
    stream_random(KSEL_CUBIC, 500);

    set_kernel(KSEL_QUARTIC);
    directed_quartic();
    stream_random(KSEL_QUARTIC, 500);

    set_kernel(KSEL_CUBIC);
    stream_random(KSEL_CUBIC, 450);

    set_kernel(KSEL_QUARTIC);
    stream_random(KSEL_QUARTIC, 450);

    // wait for the last results, then idle before the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sphk_pkg.sv
rtl/sph_spline_kernel_eval_core.sv
dv/sph_kernel_checker.sv
dv/tb_sph_spline_kernel_eval_core.sv
